### rtl/led_ring_animation_sequencer_core_macros.svh
// Assertion macros for the LED ring sequencer.
// Used by the top level; no dependencies.
`ifndef LED_RING_ANIMATION_SEQUENCER_CORE_MACROS_SVH
`define LED_RING_ANIMATION_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication
`define LRS_ASSERT_IMPLY(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error("lrs assertion failed");

// next-cycle implication
`define LRS_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error("lrs assertion failed");

`endif

### rtl/lrs_pkg.sv
// Shared types and constants for the LED ring sequencer.
// No dependencies.
`default_nettype none
package lrs_pkg;

	localparam int CHASE_GAP = 3;
	localparam int LED_W = 8;
	localparam int COLOR_W = 24;
	localparam int TIME_W = 32;
	localparam int PERIOD_W = 16;
	localparam int DUR_W = 15;
	localparam logic [LED_W-1:0] LED_COUNT_RESET = 8'd24;
	localparam logic [LED_W-1:0] GAP_RESET = LED_W'(CHASE_GAP % 24);
	localparam logic [LED_W-1:0] GAP_SRC = LED_W'(CHASE_GAP);

	// mode codes
	localparam logic [2:0] MODE_NONE  = 3'd0;
	localparam logic [2:0] MODE_SOLID = 3'd1;
	localparam logic [2:0] MODE_FLASH = 3'd2;
	localparam logic [2:0] MODE_PULSE = 3'd3;
	localparam logic [2:0] MODE_CHASE = 3'd4;
	localparam logic [2:0] MODE_HEART = 3'd5;

	// period/200 == ((period >> 3) * 10486) >> 18 for any 16-bit period
	localparam int PULSE_RECIP_W = 14;
	localparam logic [PULSE_RECIP_W-1:0] PULSE_RECIP = 14'd10486;
	localparam int PULSE_SHIFT = 18;

	localparam logic [7:0] PULSE_LAST = 8'd199;
	localparam logic [7:0] PULSE_HALF = 8'd100;
	localparam logic [7:0] PULSE_SPAN = 8'd200;
	localparam logic [7:0] PULSE_BASE = 8'd55;
	localparam logic [7:0] BRIGHT_FULL = 8'd255;

	localparam int OPQ_DEPTH = 2;
	localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
	localparam int OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);

	localparam int RED_CNT_W = $clog2(LED_W);

	typedef enum logic [1:0] {
		OP_FILL,
		OP_FLASH,
		OP_PULSE,
		OP_CHASE
	} op_kind_t;

	typedef struct packed {
		op_kind_t kind;
		logic [COLOR_W-1:0] c1;
		logic [COLOR_W-1:0] c2;
	} op_t;

	typedef struct packed {
		logic update_kind;
		logic [LED_W-1:0] head_index;
		logic [COLOR_W-1:0] head_color;
		logic [LED_W-1:0] tail_index;
		logic [COLOR_W-1:0] tail_color;
		logic brightness_set;
		logic [7:0] brightness;
	} result_t;

	typedef struct packed {
		logic busy;
		logic [LED_W-1:0] head;
		logic [LED_W-1:0] tail;
	} chase_st_t;

	typedef enum logic {
		RED_IDLE,
		RED_RUN
	} red_state_t;

endpackage
`default_nettype wire

### rtl/lrs_front.sv
// Front end: mode registers, override expiry, step timing, op issue.
// Depends on lrs_pkg.
`default_nettype none
module lrs_front
	import lrs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire logic action,
	input  wire logic [TIME_W-1:0] now_ms,
	input  wire logic [2:0] new_mode,
	input  wire logic [COLOR_W-1:0] new_color1,
	input  wire logic [COLOR_W-1:0] new_color2,
	input  wire logic [PERIOD_W-1:0] new_period,
	input  wire logic [DUR_W-1:0] duration,
	input  wire logic opq_full,
	output logic opq_push,
	output op_t opq_data
);

	logic [2:0] lmode_q, omode_q;
	logic [COLOR_W-1:0] lc1_q, lc2_q, oc1_q, oc2_q;
	logic [PERIOD_W-1:0] lthr_q, othr_q;
	logic [DUR_W-1:0] olen_q;
	logic [TIME_W-1:0] ostart_q, last_q;

	logic take, cmd;
	logic [PERIOD_W-PULSE_RECIP_W+PULSE_RECIP_W+PULSE_RECIP_W-1:0] prod;
	logic [PERIOD_W-1:0] thr_new;
	logic [TIME_W-1:0] odiff, elapsed;
	logic expired, use_o, fire, over_l, over_o;
	logic [2:0] omode_eff, mode_sel;
	logic [COLOR_W-1:0] c1_sel, c2_sel;

	assign take = push && !opq_full;
	assign cmd = action;

	// pulse threshold computed once, when the command lands
	assign prod = $bits(prod)'(new_period[PERIOD_W-1:3]) * $bits(prod)'(PULSE_RECIP);
	assign thr_new = (new_mode == MODE_PULSE) ? PERIOD_W'(prod >> PULSE_SHIFT) : new_period;

	assign odiff = now_ms - ostart_q;
	assign expired = odiff > TIME_W'(olen_q);
	assign omode_eff = expired ? MODE_NONE : omode_q;
	assign use_o = omode_eff != MODE_NONE;
	assign elapsed = now_ms - last_q;
	assign over_l = elapsed > TIME_W'(lthr_q);
	assign over_o = elapsed > TIME_W'(othr_q);

	always_comb begin
		mode_sel = use_o ? omode_eff : lmode_q;
		c1_sel = use_o ? oc1_q : lc1_q;
		c2_sel = use_o ? oc2_q : lc2_q;
		fire = 1'b0;
		opq_data.kind = OP_FILL;
		opq_data.c1 = c1_sel;
		opq_data.c2 = c2_sel;
		if (cmd) begin
			opq_data.c1 = new_color1;
			opq_data.c2 = new_color2;
		end else begin
			case (mode_sel)
				MODE_FLASH, MODE_HEART: begin
					opq_data.kind = OP_FLASH;
					fire = use_o ? over_o : over_l;
				end
				MODE_PULSE: begin
					opq_data.kind = OP_PULSE;
					fire = use_o ? over_o : over_l;
				end
				MODE_CHASE: begin
					opq_data.kind = OP_CHASE;
					fire = use_o ? over_o : over_l;
				end
				default: fire = 1'b0;
			endcase
		end
		opq_push = take && (cmd ? (new_mode == MODE_SOLID) : fire);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lmode_q <= MODE_NONE;
			omode_q <= MODE_NONE;
			lc1_q <= '0;
			lc2_q <= '0;
			oc1_q <= '0;
			oc2_q <= '0;
			lthr_q <= '0;
			othr_q <= '0;
			olen_q <= '0;
			ostart_q <= '0;
			last_q <= '0;
		end else if (take) begin
			if (cmd) begin
				if (duration != '0) begin
					omode_q <= new_mode;
					olen_q <= duration;
					ostart_q <= now_ms;
					oc1_q <= new_color1;
					oc2_q <= new_color2;
					othr_q <= thr_new;
				end else begin
					lmode_q <= new_mode;
					lc1_q <= new_color1;
					lc2_q <= new_color2;
					lthr_q <= thr_new;
				end
			end else begin
				omode_q <= omode_eff;
				if (fire)
					last_q <= now_ms;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/lrs_opq.sv
// Short op queue between front and back end.
// Depends on lrs_pkg.
`default_nettype none
module lrs_opq
	import lrs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire op_t wr_data,
	input  wire logic rd_en,
	output op_t rd_data,
	output logic full,
	output logic empty
);

	op_t mem_q [OPQ_DEPTH];
	logic [OPQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OPQ_CNT_W-1:0] cnt_q;

	assign full = cnt_q == OPQ_CNT_W'(OPQ_DEPTH);
	assign empty = cnt_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + 1'b1;
			else if (rd_en && !wr_en)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

### rtl/lrs_chase.sv
// Chase position unit: ring size register, position, gap, and the
// bit-serial remainder pass that re-reduces them after a ring size write.
// Depends on lrs_pkg.
`default_nettype none
module lrs_chase
	import lrs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [LED_W-1:0] cfg_wdata,
	input  wire logic step,
	output chase_st_t st
);

	red_state_t state_q, state_d;
	logic [LED_W-1:0] n_q, cp_q, gap_q;
	logic [LED_W-1:0] src_q, rem_cp_q, rem_g_q;
	logic [RED_CNT_W-1:0] cnt_q;
	logic red_last, busy;

	logic [LED_W:0] r_cp, r_g, pos9, back_sum;
	logic [LED_W-1:0] rem_cp_d, rem_g_d, pos, back;

	// one remainder bit per cycle, msb first
	assign r_cp = {rem_cp_q, src_q[cnt_q]};
	assign r_g = {rem_g_q, GAP_SRC[cnt_q]};
	assign rem_cp_d = (r_cp >= {1'b0, n_q}) ? LED_W'(r_cp - {1'b0, n_q}) : LED_W'(r_cp);
	assign rem_g_d = (r_g >= {1'b0, n_q}) ? LED_W'(r_g - {1'b0, n_q}) : LED_W'(r_g);

	// step: position and gap are already below n
	assign pos9 = {1'b0, cp_q} + 1'b1;
	assign pos = (pos9 == {1'b0, n_q}) ? '0 : LED_W'(pos9);
	assign back_sum = {1'b0, pos} + {1'b0, n_q} - {1'b0, gap_q};
	assign back = (back_sum >= {1'b0, n_q}) ? LED_W'(back_sum - {1'b0, n_q})
		: LED_W'(back_sum);

	always_comb begin
		state_d = state_q;
		case (state_q)
			RED_IDLE: if (cfg_we) state_d = RED_RUN;
			RED_RUN: if (!cfg_we && cnt_q == '0) state_d = RED_IDLE;
			default: state_d = RED_IDLE;
		endcase
	end

	always_comb begin
		busy = 1'b0;
		red_last = 1'b0;
		case (state_q)
			RED_RUN: begin
				busy = 1'b1;
				red_last = !cfg_we && cnt_q == '0;
			end
			default: begin
				busy = 1'b0;
				red_last = 1'b0;
			end
		endcase
	end

	assign st.busy = busy;
	assign st.head = n_q - 1'b1 - pos;
	assign st.tail = n_q - 1'b1 - back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RED_IDLE;
			n_q <= LED_COUNT_RESET;
			cp_q <= '0;
			gap_q <= GAP_RESET;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				n_q <= (cfg_wdata == '0) ? LED_W'(1) : cfg_wdata;
				cnt_q <= RED_CNT_W'(LED_W - 1);
			end else if (busy) begin
				cnt_q <= cnt_q - 1'b1;
				if (red_last) begin
					cp_q <= rem_cp_d;
					gap_q <= rem_g_d;
				end
			end else if (step) begin
				cp_q <= pos;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cfg_we) begin
			src_q <= cp_q;
			rem_cp_q <= '0;
			rem_g_q <= '0;
		end else if (busy) begin
			rem_cp_q <= rem_cp_d;
			rem_g_q <= rem_g_d;
		end
	end

endmodule
`default_nettype wire

### rtl/lrs_back.sv
// Back end: carries out queued ops, holds animation phase and the
// result register.
// Depends on lrs_pkg and lrs_chase.
`default_nettype none
module lrs_back
	import lrs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [LED_W-1:0] cfg_wdata,
	input  wire logic opq_empty,
	input  wire op_t opq_data,
	output logic opq_pop,
	input  wire logic pop,
	output logic empty,
	output result_t res,
	output logic chase_busy
);

	chase_st_t cst;
	logic res_valid_q;
	result_t res_q, res_d;
	logic flash_q;
	logic [7:0] pstep_q;
	logic [7:0] t;
	logic take, step;

	lrs_chase u_chase (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.step(step),
		.st(cst)
	);

	assign take = !opq_empty && !cst.busy && (!res_valid_q || pop);
	assign opq_pop = take;
	assign step = take && opq_data.kind == OP_CHASE;
	assign t = (pstep_q < PULSE_HALF) ? pstep_q : PULSE_SPAN - pstep_q;

	always_comb begin
		res_d.update_kind = 1'b0;
		res_d.head_index = '0;
		res_d.head_color = opq_data.c1;
		res_d.tail_index = '0;
		res_d.tail_color = '0;
		res_d.brightness_set = 1'b1;
		res_d.brightness = BRIGHT_FULL;
		case (opq_data.kind)
			OP_FILL: begin
				res_d.brightness_set = 1'b0;
				res_d.brightness = '0;
			end
			OP_FLASH: res_d.head_color = flash_q ? opq_data.c2 : opq_data.c1;
			OP_PULSE: res_d.brightness = {t[6:0], 1'b0} + PULSE_BASE;
			OP_CHASE: begin
				res_d.update_kind = 1'b1;
				res_d.head_index = cst.head;
				res_d.tail_index = cst.tail;
				res_d.tail_color = opq_data.c2;
			end
			default: res_d.brightness = BRIGHT_FULL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			flash_q <= 1'b0;
			pstep_q <= '0;
		end else begin
			if (take)
				res_valid_q <= 1'b1;
			else if (pop)
				res_valid_q <= 1'b0;
			if (take && opq_data.kind == OP_FLASH)
				flash_q <= !flash_q;
			if (take && opq_data.kind == OP_PULSE)
				pstep_q <= (pstep_q == PULSE_LAST) ? '0 : pstep_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			res_q <= res_d;
	end

	assign empty = !res_valid_q;
	assign res = res_q;
	assign chase_busy = cst.busy;

endmodule
`default_nettype wire

### rtl/led_ring_animation_sequencer_core.sv
// LED ring animation sequencer, top level.
// Depends on lrs_pkg, lrs_front, lrs_opq, lrs_back and the macro header.
//
// Use: items (millisecond ticks or set-mode commands) go in through push/full;
// an item is taken on a rising edge with push high and full low. Each item
// yields zero or one ring update; updates come out through empty/pop, the
// oldest on the result ports while empty is low, taken with pop high.
// The front end keeps the mode registers and step timing and decides at the
// accept edge whether the item yields an update; if so an op goes into a
// two-entry queue. The back end turns ops into updates (flash phase, pulse
// triangle, chase indices) and loads the result register.
// An update is registered in the op queue, then in the result register.
// Throughput: one item per cycle while pop keeps up, outside a remainder pass.
// When pop is held low the result register holds, the queue fills, and full
// rises after two more updating items; items that yield no update still wait.
// A write of cfg_we/cfg_wdata sets the ring size and starts a bit-serial
// remainder pass that re-reduces the chase position and gap; ops queue and
// wait during it. Reset: ring size 24, all modes none, outputs empty.
`default_nettype none
`include "led_ring_animation_sequencer_core_macros.svh"
module led_ring_animation_sequencer_core
	import lrs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [LED_W-1:0] cfg_wdata,
	input  wire logic push,
	output logic full,
	input  wire logic action,
	input  wire logic [TIME_W-1:0] now_ms,
	input  wire logic [2:0] new_mode,
	input  wire logic [COLOR_W-1:0] new_color1,
	input  wire logic [COLOR_W-1:0] new_color2,
	input  wire logic [PERIOD_W-1:0] new_period,
	input  wire logic [DUR_W-1:0] duration,
	output logic empty,
	input  wire logic pop,
	output logic update_kind,
	output logic [LED_W-1:0] head_index,
	output logic [COLOR_W-1:0] head_color,
	output logic [LED_W-1:0] tail_index,
	output logic [COLOR_W-1:0] tail_color,
	output logic brightness_set,
	output logic [7:0] brightness
);

	logic opq_push, opq_pop, opq_full, opq_empty;
	op_t opq_wdata, opq_rdata;
	result_t res;
	logic chase_busy;

	// full follows the op queue: front accepts whenever there is room
	assign full = opq_full;

	lrs_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.action(action),
		.now_ms(now_ms),
		.new_mode(new_mode),
		.new_color1(new_color1),
		.new_color2(new_color2),
		.new_period(new_period),
		.duration(duration),
		.opq_full(opq_full),
		.opq_push(opq_push),
		.opq_data(opq_wdata)
	);

	lrs_opq u_opq (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(opq_push),
		.wr_data(opq_wdata),
		.rd_en(opq_pop),
		.rd_data(opq_rdata),
		.full(opq_full),
		.empty(opq_empty)
	);

	lrs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.opq_empty(opq_empty),
		.opq_data(opq_rdata),
		.opq_pop(opq_pop),
		.pop(pop),
		.empty(empty),
		.res(res),
		.chase_busy(chase_busy)
	);

	assign update_kind = res.update_kind;
	assign head_index = res.head_index;
	assign head_color = res.head_color;
	assign tail_index = res.tail_index;
	assign tail_color = res.tail_color;
	assign brightness_set = res.brightness_set;
	assign brightness = res.brightness;

	// no op issued while the ring size pass runs
	`LRS_ASSERT_IMPLY(a_no_pop_busy, clk, arst_n, chase_busy, !opq_pop)
	// a ring size write always starts the pass
	`LRS_ASSERT_NEXT(a_cfg_starts_pass, clk, arst_n, cfg_we, chase_busy)
	// every issued op lands in the result register
	`LRS_ASSERT_NEXT(a_pop_gives_result, clk, arst_n, opq_pop, !empty)

endmodule
`default_nettype wire
